// ===== rtl/dbq_pkg.sv =====
package dbq_pkg;

  localparam int DEF_QUEUE_DEPTH     = 8;
  localparam int DEF_MAX_DMA_SAMPLES = 16384;

  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 24;
  localparam int BYTES_W     = 17;
  localparam int SAMP_W      = 15;
  localparam int IDX_MAX_W   = 6;
  localparam int JOBQ_DEPTH  = 2;

  localparam logic CMD_SUBMIT   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_SPURIOUS = 2'd2;

  typedef struct packed {
    logic              command;
    logic              channel;
    logic [ADDR_W-1:0] buf_address;
    logic [CNT_W-1:0]  sample_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               out_channel;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  address;
    logic [BYTES_W-1:0] byte_count;
    logic [SAMP_W-1:0]  done_samples;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_SUBMIT,
    JOB_FULL,
    JOB_SPURIOUS,
    JOB_COMPLETE
  } job_op_t;

  typedef struct packed {
    job_op_t              op;
    logic                 channel;
    logic                 start_next;
    logic [IDX_MAX_W-1:0] idx_a;
    logic [IDX_MAX_W-1:0] idx_b;
    logic [ADDR_W-1:0]    address;
    logic [CNT_W-1:0]     count;
  } job_t;

endpackage

// ===== rtl/dbq_front.sv =====
module dbq_front #(
  parameter int          QUEUE_DEPTH     = dbq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_DMA_SAMPLES = dbq_pkg::DEF_MAX_DMA_SAMPLES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dbq_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output dbq_pkg::job_t     q_job
);
  import dbq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   MAX_EXT  = MAX_DMA_SAMPLES[CNT_W:0];

  logic [IDX_W-1:0] wr_idx_r [2];
  logic [IDX_W-1:0] rd_idx_r [2];
  logic [LVL_W-1:0] level_r  [2];

  logic [IDX_W-1:0] wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_nxt;
  logic [LVL_W-1:0] level_nxt;
  logic             upd;
  logic             ch;
  logic [CNT_W-1:0] cnt_clamped;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    ch          = in_item.channel;
    q_push      = start && !q_full;
    upd         = 1'b0;
    wr_idx_nxt  = wr_idx_r[ch];
    rd_idx_nxt  = rd_idx_r[ch];
    level_nxt   = level_r[ch];
    cnt_clamped = ({1'b0, in_item.sample_count} > MAX_EXT) ? MAX_EXT[CNT_W-1:0]
                                                           : in_item.sample_count;
    q_job            = '0;
    q_job.channel    = ch;
    q_job.address    = in_item.buf_address;
    q_job.count      = cnt_clamped;
    q_job.idx_a      = IDX_MAX_W'(wr_idx_r[ch]);
    if (in_item.command == CMD_SUBMIT) begin
      if (level_r[ch] == LVL_FULL) begin
        q_job.op = JOB_FULL;
      end else begin
        q_job.op         = JOB_SUBMIT;
        q_job.start_next = (level_r[ch] == '0);
        upd              = 1'b1;
        wr_idx_nxt       = adv(wr_idx_r[ch]);
        level_nxt        = level_r[ch] + 1'b1;
      end
    end else begin
      q_job.idx_a = IDX_MAX_W'(rd_idx_r[ch]);
      q_job.idx_b = IDX_MAX_W'(adv(rd_idx_r[ch]));
      if (level_r[ch] == '0) begin
        q_job.op = JOB_SPURIOUS;
      end else begin
        q_job.op         = JOB_COMPLETE;
        q_job.start_next = (level_r[ch] != LVL_W'(1));
        upd              = 1'b1;
        rd_idx_nxt       = adv(rd_idx_r[ch]);
        level_nxt        = level_r[ch] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        wr_idx_r[c] <= '0;
        rd_idx_r[c] <= '0;
        level_r[c]  <= '0;
      end
    end else if (q_push && upd) begin
      wr_idx_r[ch] <= wr_idx_nxt;
      rd_idx_r[ch] <= rd_idx_nxt;
      level_r[ch]  <= level_nxt;
    end
  end

endmodule

// ===== rtl/dbq_fifo.sv =====
module dbq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dbq_pkg::job_t push_job,
  input  logic          pop,
  output dbq_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import dbq_pkg::*;

  localparam int PTR_W = $clog2(JOBQ_DEPTH);
  localparam int CNT_FW = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);
  localparam logic [CNT_FW-1:0] CNT_FULL = CNT_FW'(JOBQ_DEPTH);

  job_t              slot_r [JOBQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_FW-1:0] cnt_r;
  logic [CNT_FW-1:0] cnt_nxt;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dbq_back.sv =====
module dbq_back #(
  parameter int QUEUE_DEPTH = dbq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dbq_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  output dbq_pkg::out_item_t out_item
);
  import dbq_pkg::*;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENTRY_W = ADDR_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SECOND = 4'b0010,
    S_DONE   = 4'b0100,
    S_NEXT   = 4'b1000
  } back_state_t;

  logic [ENTRY_W-1:0] ring_mem [2][QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_ch;
  logic [IDX_W-1:0]   rd_idx;
  logic               wr_en;

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_cnt;

  assign rd_addr   = rd_data_r[ENTRY_W-1:CNT_W];
  assign rd_cnt    = rd_data_r[CNT_W-1:0];
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_ch         = job_r.channel;
    rd_idx        = job_r.idx_b[IDX_W-1:0];
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.out_channel = job_r.channel;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop               = 1'b1;
          job_nxt             = q_job;
          rd_ch               = q_job.channel;
          rd_idx              = q_job.idx_a[IDX_W-1:0];
          out_nxt.out_channel = q_job.channel;
          unique case (q_job.op)
            JOB_SUBMIT: begin
              wr_en          = 1'b1;
              out_valid_nxt  = 1'b1;
              out_nxt.kind   = KIND_STATUS;
              out_nxt.status = ST_OK;
              out_nxt.last   = !q_job.start_next;
              if (q_job.start_next) begin
                state_nxt = S_SECOND;
              end
            end
            JOB_FULL: begin
              out_valid_nxt  = 1'b1;
              out_nxt.kind   = KIND_STATUS;
              out_nxt.status = ST_FULL;
              out_nxt.last   = 1'b1;
            end
            JOB_SPURIOUS: begin
              out_valid_nxt  = 1'b1;
              out_nxt.kind   = KIND_DONE;
              out_nxt.status = ST_SPURIOUS;
              out_nxt.last   = 1'b1;
            end
            JOB_COMPLETE: begin
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SECOND: begin
        out_valid_nxt      = 1'b1;
        out_nxt.kind       = KIND_START;
        out_nxt.address    = job_r.address;
        out_nxt.byte_count = {job_r.count[SAMP_W-1:0], 2'b00};
        out_nxt.last       = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_DONE: begin
        out_valid_nxt        = 1'b1;
        out_nxt.kind         = KIND_DONE;
        out_nxt.address      = rd_addr;
        out_nxt.byte_count   = {rd_cnt[SAMP_W-1:0], 2'b00};
        out_nxt.done_samples = rd_cnt[SAMP_W-1:0];
        state_nxt            = S_NEXT;
      end
      S_NEXT: begin
        out_valid_nxt = 1'b1;
        out_nxt.last  = 1'b1;
        if (job_r.start_next) begin
          out_nxt.kind       = KIND_START;
          out_nxt.address    = rd_addr;
          out_nxt.byte_count = {rd_cnt[SAMP_W-1:0], 2'b00};
        end else begin
          out_nxt.kind = KIND_STOP;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[q_job.channel][q_job.idx_a[IDX_W-1:0]] <= {q_job.address, q_job.count};
    end
    rd_data_r <= ring_mem[rd_ch][rd_idx];
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_then_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (state_r == S_NEXT && out_valid_r && out_r.kind == KIND_DONE))
    else $error("completion did not report the finished buffer");

  a_second_is_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SECOND) |=> (out_valid_r && out_r.kind == KIND_START && out_r.last))
    else $error("submit on empty queue did not start DMA");

  a_not_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |=> out_valid_r)
    else $error("non-final result not followed by another");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !q_empty))
    else $error("job taken while busy");

endmodule

// ===== rtl/dma_buffer_chain_queue.sv =====
// Channel   Ports                          Handshake
// input     start, busy, in_item           transfer when start && !busy
// result    out_valid, out_item            one-cycle strobe, always taken
//
// A transfer is classified in its accept cycle and queued as a job (two-entry queue).
// Back end: full status, spurious completion: one result; submit: status, plus start if its
// ring was empty; completion: done, then start/stop (registered ring reads: head, next).
// busy is high while the job queue is full.
// rst_n (synchronous) empties both ring queues; ring storage is not cleared.
// Results cannot be stalled; out_valid marks each result for exactly one cycle.
module dma_buffer_chain_queue #(
  parameter int          QUEUE_DEPTH     = dbq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_DMA_SAMPLES = dbq_pkg::DEF_MAX_DMA_SAMPLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dbq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dbq_pkg::out_item_t out_item
);
  import dbq_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  assign busy = q_full;

  dbq_front #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MAX_DMA_SAMPLES (MAX_DMA_SAMPLES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  dbq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  dbq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== sim/dbq_checker.sv =====
module dbq_checker #(
  parameter int          QUEUE_DEPTH     = dbq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_DMA_SAMPLES = dbq_pkg::DEF_MAX_DMA_SAMPLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  dbq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  dbq_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import dbq_pkg::*;

  logic [ADDR_W-1:0] ring_addr [2][QUEUE_DEPTH];
  logic [CNT_W-1:0]  ring_cnt  [2][QUEUE_DEPTH];
  int                wr_idx    [2];
  int                rd_idx    [2];
  int                level     [2];
  out_item_t         due_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic out_item_t make_result(logic [1:0] kind, logic ch, logic [1:0] st,
                                            logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt,
                                            bit with_bytes, bit with_done, logic last);
    out_item_t r;
    logic [CNT_W+1:0] bytes;
    bytes          = {cnt, 2'b00};
    r.kind         = kind;
    r.out_channel  = ch;
    r.status       = st;
    r.address      = addr;
    r.byte_count   = with_bytes ? bytes[BYTES_W-1:0] : '0;
    r.done_samples = with_done ? cnt[SAMP_W-1:0] : '0;
    r.last         = last;
    return r;
  endfunction

  function automatic int next_idx(int i);
    return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
  endfunction

  task automatic predict_transfer(in_item_t it);
    logic              ch;
    logic [CNT_W-1:0]  cnt;
    int                r;
    ch = it.channel;
    if (it.command == CMD_SUBMIT) begin
      if (level[ch] >= QUEUE_DEPTH) begin
        due_results.push_back(make_result(KIND_STATUS, ch, ST_FULL, '0, '0, 1'b0, 1'b0,
                                          1'b1));
      end else begin
        cnt = (it.sample_count > MAX_DMA_SAMPLES) ? CNT_W'(MAX_DMA_SAMPLES) : it.sample_count;
        ring_addr[ch][wr_idx[ch]] = it.buf_address;
        ring_cnt[ch][wr_idx[ch]]  = cnt;
        wr_idx[ch] = next_idx(wr_idx[ch]);
        level[ch]++;
        if (level[ch] == 1) begin
          due_results.push_back(make_result(KIND_STATUS, ch, ST_OK, '0, '0, 1'b0, 1'b0,
                                            1'b0));
          due_results.push_back(make_result(KIND_START, ch, ST_OK, it.buf_address, cnt,
                                            1'b1, 1'b0, 1'b1));
        end else begin
          due_results.push_back(make_result(KIND_STATUS, ch, ST_OK, '0, '0, 1'b0, 1'b0,
                                            1'b1));
        end
      end
    end else begin
      if (level[ch] == 0) begin
        due_results.push_back(make_result(KIND_DONE, ch, ST_SPURIOUS, '0, '0, 1'b0, 1'b0,
                                          1'b1));
      end else begin
        r = rd_idx[ch];
        due_results.push_back(make_result(KIND_DONE, ch, ST_OK, ring_addr[ch][r],
                                          ring_cnt[ch][r], 1'b1, 1'b1, 1'b0));
        r = next_idx(r);
        rd_idx[ch] = r;
        level[ch]--;
        if (level[ch] > 0)
          due_results.push_back(make_result(KIND_START, ch, ST_OK, ring_addr[ch][r],
                                            ring_cnt[ch][r], 1'b1, 1'b0, 1'b1));
        else
          due_results.push_back(make_result(KIND_STOP, ch, ST_OK, '0, '0, 1'b0, 1'b0,
                                            1'b1));
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name,
               exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      wr_idx = '{0, 0};
      rd_idx = '{0, 0};
      level  = '{0, 0};
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $realtime, out_item);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("kind", 64'(exp_r.kind), 64'(out_item.kind));
          check_field("out_channel", 64'(exp_r.out_channel), 64'(out_item.out_channel));
          check_field("status", 64'(exp_r.status), 64'(out_item.status));
          check_field("address", 64'(exp_r.address), 64'(out_item.address));
          check_field("byte_count", 64'(exp_r.byte_count), 64'(out_item.byte_count));
          check_field("done_samples", 64'(exp_r.done_samples),
                      64'(out_item.done_samples));
          check_field("last", 64'(exp_r.last), 64'(out_item.last));
        end
      end
      if (start && !busy)
        predict_transfer(in_item);
    end
    pending = due_results.size();
  end

endmodule

// ===== sim/dma_buffer_chain_queue_tb.sv =====
module dma_buffer_chain_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dbq_pkg::*;

  localparam int RANDOM_ITEMS     = 500;
  localparam int QUIET_TAIL       = 100;
  localparam int STALL_LIMIT      = 2000;
  localparam int QUEUE_DEPTH_FILL = DEF_QUEUE_DEPTH + 1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        stall_cycles;

  dma_buffer_chain_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  dbq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic transfer(logic cmd, logic ch, logic [ADDR_W-1:0] addr,
                          logic [CNT_W-1:0] cnt);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= '{command: cmd, channel: ch, buf_address: addr, sample_count: cnt};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 3))
      0:       return CNT_W'($urandom_range(0, 31));
      1:       return CNT_W'($urandom_range(DEF_MAX_DMA_SAMPLES - 4, DEF_MAX_DMA_SAMPLES + 4));
      2:       return CNT_W'($urandom);
      default: return CNT_W'($urandom_range(0, DEF_MAX_DMA_SAMPLES));
    endcase
  endfunction

  initial begin
    int submit_pct;
    int idle_pct;
    logic cmd;
    stall_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    transfer(CMD_COMPLETE, 1'b0, '1, '1);
    transfer(CMD_COMPLETE, 1'b1, '0, '0);
    transfer(CMD_SUBMIT, 1'b0, '0, '0);
    transfer(CMD_SUBMIT, 1'b0, '1, '1);
    transfer(CMD_SUBMIT, 1'b0, 32'h5555_aaaa, CNT_W'(DEF_MAX_DMA_SAMPLES));
    transfer(CMD_SUBMIT, 1'b0, 32'haaaa_5555, CNT_W'(DEF_MAX_DMA_SAMPLES + 1));
    transfer(CMD_SUBMIT, 1'b0, 32'h8000_0001, CNT_W'(DEF_MAX_DMA_SAMPLES - 1));
    transfer(CMD_SUBMIT, 1'b0, 32'h0000_0004, 24'h7fff);
    hold_off(3);
    transfer(CMD_SUBMIT, 1'b0, 32'hdead_beef, 24'h00_0001);
    transfer(CMD_SUBMIT, 1'b0, 32'h1234_5678, 24'h80_0000);
    transfer(CMD_SUBMIT, 1'b0, 32'hffff_0000, 24'h00_0010);
    transfer(CMD_SUBMIT, 1'b1, 32'h0bad_f00d, 24'h00_0100);
    repeat (QUEUE_DEPTH_FILL) transfer(CMD_COMPLETE, 1'b0, '0, '0);
    transfer(CMD_COMPLETE, 1'b1, '0, '0);
    transfer(CMD_COMPLETE, 1'b1, '1, '1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       submit_pct = 15;
          1:       submit_pct = 50;
          default: submit_pct = 85;
        endcase
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      cmd = ($urandom_range(0, 99) < submit_pct) ? CMD_SUBMIT : CMD_COMPLETE;
      transfer(cmd, 1'($urandom), $urandom, pick_count());
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
        hold_off($urandom_range(1, 19));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== dma_buffer_chain_queue.f =====
rtl/dbq_pkg.sv
rtl/dbq_front.sv
rtl/dbq_fifo.sv
rtl/dbq_back.sv
rtl/dma_buffer_chain_queue.sv
sim/dbq_checker.sv
sim/dma_buffer_chain_queue_tb.sv
